/* sv/lpvd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpvd_pkg
// Widths and header bit masks for the length-prefixed varint decoder.
// ----------------------------------------------------------------------------
package lpvd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ValueW = 64;
  localparam int unsigned CountW = 7;
  localparam int unsigned MaxBytes = ValueW / ByteW;

  localparam logic [ByteW-1:0] SgnLongBit = 8'h40;
  localparam logic [ByteW-1:0] SgnLowMask = 8'h3F;
  localparam logic [ByteW-1:0] HdrTopBit  = 8'h80;
  localparam logic [ByteW-1:0] UnsLowMask = 8'h7F;

  typedef enum logic {
    FMT_UNSIGNED = 1'b0,
    FMT_SIGNED   = 1'b1
  } fmt_e;

endpackage

/* sv/length_prefixed_varint_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_varint_decoder
// Decodes unsigned and signed length-prefixed varints from a byte stream.
// ----------------------------------------------------------------------------
// The block takes one stream byte per cycle and gives one 64-bit value per
// decoded integer. A header byte is flagged unsigned or signed on tuser; body
// bytes ignore tuser. Short forms and zero-count long forms give their result
// from the header byte alone; long forms give it from the last body byte.
// Each byte is folded into the accumulator by combinational logic feeding a
// result register, so a byte can be taken every cycle while that register is
// free or being drained. Counts above eight keep the low 64 bits and set the
// overlong flag on the result.
module length_prefixed_varint_decoder
  import lpvd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [ByteW-1:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic              s_axis_tuser,   // [0] cmd
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [ValueW-1:0] m_axis_tdata,   // [63:0] value
  output logic              m_axis_tuser    // [0] overlong
);

  logic              in_body_q, in_body_d;
  logic [CountW-1:0] bytes_left_q, bytes_left_d;
  logic [CountW-1:0] byte_pos_q, byte_pos_d;
  logic [ValueW-1:0] accum_q, accum_d;
  logic              negate_q, negate_d;

  logic              out_valid_q, out_valid_d;
  logic [ValueW-1:0] out_value_q, out_value_d;
  logic              out_over_q, out_over_d;

  logic              accept;
  logic              emit;
  logic [ValueW-1:0] emit_mag;
  logic              emit_neg;
  logic              emit_over;
  logic [ValueW-1:0] shifted;
  logic [ByteW-1:0]  hdr_low;
  logic              hdr_short;
  logic              hdr_neg;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign shifted = {{(ValueW-ByteW){1'b0}}, s_axis_tdata}
                   << {byte_pos_q[2:0], 3'b000};

  always_comb begin
    in_body_d    = in_body_q;
    bytes_left_d = bytes_left_q;
    byte_pos_d   = byte_pos_q;
    accum_d      = accum_q;
    negate_d     = negate_q;
    emit         = 1'b0;
    emit_mag     = '0;
    emit_neg     = 1'b0;
    emit_over    = 1'b0;
    hdr_low      = '0;
    hdr_short    = 1'b0;
    hdr_neg      = 1'b0;

    if (in_body_q) begin
      if (byte_pos_q < CountW'(MaxBytes)) begin
        accum_d = accum_q | shifted;
      end
      byte_pos_d   = byte_pos_q + CountW'(1);
      bytes_left_d = bytes_left_q - CountW'(1);
      if (bytes_left_d == '0) begin
        in_body_d = 1'b0;
        emit      = 1'b1;
        emit_mag  = accum_d;
        emit_neg  = negate_q;
        emit_over = byte_pos_d > CountW'(MaxBytes);
      end
    end else begin
      if (fmt_e'(s_axis_tuser) == FMT_SIGNED) begin
        hdr_neg   = (s_axis_tdata & HdrTopBit) != '0;
        hdr_short = (s_axis_tdata & SgnLongBit) == '0;
        hdr_low   = s_axis_tdata & SgnLowMask;
      end else begin
        hdr_short = (s_axis_tdata & HdrTopBit) == '0;
        hdr_low   = s_axis_tdata & UnsLowMask;
      end
      if (hdr_short) begin
        emit     = 1'b1;
        emit_mag = {{(ValueW-ByteW){1'b0}}, hdr_low};
        emit_neg = hdr_neg;
      end else if (hdr_low == '0) begin
        emit = 1'b1;
      end else begin
        in_body_d    = 1'b1;
        bytes_left_d = hdr_low[CountW-1:0];
        byte_pos_d   = '0;
        accum_d      = '0;
        negate_d     = hdr_neg;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;
    out_over_d  = out_over_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (accept && emit) begin
      out_valid_d = 1'b1;
      out_value_d = emit_neg ? (ValueW'(0) - emit_mag) : emit_mag;
      out_over_d  = emit_over;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_body_q    <= 1'b0;
      bytes_left_q <= '0;
      byte_pos_q   <= '0;
      accum_q      <= '0;
      negate_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        in_body_q    <= in_body_d;
        bytes_left_q <= bytes_left_d;
        byte_pos_q   <= byte_pos_d;
        accum_q      <= accum_d;
        negate_q     <= negate_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    out_over_q  <= out_over_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = out_over_q;

endmodule
